FILE: rtl/wma_pkg.sv
// wma_pkg: shared types and constants for the wavelet matrix build/access block.
// No dependencies.
`default_nettype none
package wma_pkg;
  localparam int SYM_W = 5;
  localparam int IDX_W = 10;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic [IDX_W-1:0] index;
  } wma_in_t;

  typedef struct packed {
    logic [SYM_W-1:0] value;
    logic             error;
  } wma_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B_SCAN,
    ST_B_SCAN_W,
    ST_B_MOVE,
    ST_B_MOVE_W,
    ST_B_NEXT,
    ST_Q_RD,
    ST_Q_WAIT,
    ST_Q_STEP,
    ST_OUT
  } wma_state_t;
endpackage
`default_nettype wire

FILE: rtl/wma_core.sv
// wma_core: sequencer for the build and access of the wavelet matrix.
// Depends on wma_pkg.
`default_nettype none
module wma_core import wma_pkg::*; #(
  parameter int MAX_LEN = 1024,
  parameter int LEVELS  = 5
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire wma_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output wma_out_t      out_data
);
  localparam int AW  = $clog2(MAX_LEN);
  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int DW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int VW  = (LEVELS > SYM_W) ? LEVELS : SYM_W;
  localparam int BAW = $clog2(LEVELS * MAX_LEN);
  localparam int PAW = $clog2(LEVELS * (MAX_LEN + 1));
  localparam logic [DW-1:0] LAST_LVL = DW'(LEVELS - 1);

  logic [SYM_W-1:0] wbuf [2][MAX_LEN];
  logic             bplane [LEVELS*MAX_LEN];
  logic [LW-1:0]    oprefix [LEVELS*(MAX_LEN+1)];
  logic [LW-1:0]    zcnt_r [LEVELS];

  wma_state_t state_r, state_nxt;
  logic [LW-1:0]    len_r;
  logic             built_r;
  logic             src_r;
  logic [DW-1:0]    lvl_r;
  logic [LW-1:0]    i_r, ones_r, zp_r, op_r;
  logic [LW-1:0]    qi_r;
  logic [VW-1:0]    val_r;
  logic [SYM_W-1:0] rd_sym_r;
  logic             rd_bit_r;
  logic [LW-1:0]    rd_pre_r;
  wma_out_t         res_r;

  logic [BAW-1:0]   bp_addr;
  logic [PAW-1:0]   op_addr;
  logic [LW-1:0]    rd_idx;
  logic [SYM_W-1:0] rd_shift;
  logic             rd_b;
  logic [LW-1:0]    step_sum;

  assign rd_idx = (state_r == ST_Q_RD) ? qi_r : i_r;
  assign bp_addr = BAW'(lvl_r) * BAW'(MAX_LEN) + BAW'(rd_idx);
  assign op_addr = PAW'(lvl_r) * PAW'(MAX_LEN + 1) + PAW'(rd_idx);
  // levels past the symbol width shift everything out and read zero
  assign rd_shift = rd_sym_r >> lvl_r;
  assign rd_b = rd_shift[0];
  assign step_sum = rd_bit_r ? (zcnt_r[lvl_r] + rd_pre_r) : (qi_r - rd_pre_r);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.cmd == CMD_LOAD) begin
            if (in_data.last) state_nxt = ST_B_SCAN;
          end else begin
            state_nxt = (!built_r || LW'(in_data.index) >= len_r) ? ST_OUT : ST_Q_RD;
          end
        end
      end
      ST_B_SCAN:   state_nxt = (i_r == len_r) ? ST_B_MOVE : ST_B_SCAN_W;
      ST_B_SCAN_W: state_nxt = ST_B_SCAN;
      ST_B_MOVE:   state_nxt = (i_r == len_r) ? ST_B_NEXT : ST_B_MOVE_W;
      ST_B_MOVE_W: state_nxt = ST_B_MOVE;
      ST_B_NEXT:   state_nxt = (lvl_r == LAST_LVL) ? ST_IDLE : ST_B_SCAN;
      ST_Q_RD:     state_nxt = ST_Q_WAIT;
      ST_Q_WAIT:   state_nxt = ST_Q_STEP;
      ST_Q_STEP:   state_nxt = (lvl_r == LAST_LVL) ? ST_OUT : ST_Q_RD;
      ST_OUT:      state_nxt = out_stall ? ST_OUT : ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      built_r <= 1'b0;
      for (int k = 0; k < LEVELS; k++) zcnt_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_data.cmd == CMD_LOAD) begin
            if (built_r || len_r != LW'(MAX_LEN)) begin
              len_r <= built_r ? LW'(1) : len_r + 1'b1;
            end else begin
              len_r <= len_r;
            end
            built_r <= 1'b0;
          end
        end
        ST_B_SCAN: begin
          if (i_r == len_r) zcnt_r[lvl_r] <= len_r - ones_r;
        end
        ST_B_NEXT: begin
          if (lvl_r == LAST_LVL) built_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        lvl_r  <= '0;
        i_r    <= '0;
        ones_r <= '0;
        src_r  <= 1'b0;
        val_r  <= '0;
        qi_r   <= LW'(in_data.index);
        res_r  <= '{value: '0, error: 1'b1};
        if (in_valid && in_data.cmd == CMD_LOAD && (built_r || len_r != LW'(MAX_LEN)))
          wbuf[0][built_r ? '0 : AW'(len_r)] <= in_data.symbol;
        if (in_valid && in_data.cmd == CMD_LOAD && in_data.last)
          oprefix[0] <= '0;
      end
      ST_B_SCAN: begin
        if (i_r == len_r) begin
          i_r  <= '0;
          zp_r <= '0;
          op_r <= len_r - ones_r;
        end else begin
          rd_sym_r <= wbuf[src_r][AW'(i_r)];
        end
      end
      ST_B_SCAN_W: begin
        bplane[bp_addr]         <= rd_b;
        oprefix[op_addr + 1'b1] <= ones_r + LW'(rd_b);
        ones_r <= ones_r + LW'(rd_b);
        i_r    <= i_r + 1'b1;
      end
      ST_B_MOVE: begin
        if (i_r != len_r) rd_sym_r <= wbuf[src_r][AW'(i_r)];
      end
      ST_B_MOVE_W: begin
        if (rd_b) begin
          wbuf[!src_r][AW'(op_r)] <= rd_sym_r;
          op_r <= op_r + 1'b1;
        end else begin
          wbuf[!src_r][AW'(zp_r)] <= rd_sym_r;
          zp_r <= zp_r + 1'b1;
        end
        i_r <= i_r + 1'b1;
      end
      ST_B_NEXT: begin
        src_r  <= !src_r;
        lvl_r  <= lvl_r + 1'b1;
        i_r    <= '0;
        ones_r <= '0;
        if (lvl_r != LAST_LVL)
          oprefix[PAW'(lvl_r + 1'b1) * PAW'(MAX_LEN + 1)] <= '0;
      end
      ST_Q_RD: begin
        rd_bit_r <= bplane[bp_addr];
        rd_pre_r <= oprefix[op_addr];
      end
      ST_Q_STEP: begin
        val_r[lvl_r] <= rd_bit_r;
        qi_r  <= step_sum;
        lvl_r <= lvl_r + 1'b1;
        if (lvl_r == LAST_LVL) begin
          res_r.value <= (SYM_W'(val_r) & ~(SYM_W'(1) << lvl_r)) |
                         ((32'(lvl_r) < SYM_W) ? (SYM_W'(rd_bit_r) << lvl_r) : '0);
          res_r.error <= 1'b0;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/wavelet_matrix_build_access.sv
// Wavelet matrix build and access: usage overview.
// Depends on wma_pkg and wma_core.
//
// in_*: one transaction per item; cmd 0 loads a symbol, last starts the build.
// out_*: one transaction per query (value, error); loads produce none.
// The build runs LEVELS levels, each two passes (each a buffer read then
// write per item) plus a level step; in_stall is high.
// A query steps through a read, a wait and a step state per level through the
// shared index adder; an error answer is ready the next cycle.
// The result is held in a register until the receiver drops out_stall; no
// new transaction is taken until then.
// After reset the matrix is empty: queries answer error until a build ends.
// Memories are not cleared; only the state, the sequence length, zero counts
// and the built flag reset.
`default_nettype none
module wavelet_matrix_build_access import wma_pkg::*; #(
  parameter int MAX_LEN = 1024,
  parameter int LEVELS  = 5
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire wma_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output wma_out_t     out_data
);
  wma_core #(.MAX_LEN(MAX_LEN), .LEVELS(LEVELS)) u_core (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );
endmodule
`default_nettype wire

FILE: rtl/wma_checker.sv
// wma_checker: port-level assertions for the wavelet matrix block.
// Depends on wma_pkg; bound to wavelet_matrix_build_access.
`default_nettype none
module wma_checker import wma_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire wma_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire wma_out_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.value == '0)
    else $error("error result carries nonzero value");
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.cmd == CMD_LOAD |=> !out_valid)
    else $error("load produced a result");
endmodule

bind wavelet_matrix_build_access wma_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
);
`default_nettype wire
